[rtl/core/cqir_pkg.sv]
// Shared types and defaults for the collapsing queue with indexed remove.
// No dependencies; compile first.
`default_nettype none

package cqir_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int OCC_W   = 5;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // per-cell control for the current cycle
  typedef struct packed {
    logic load;   // take the appended word
    logic shift;  // take the neighbor's word (collapse toward head)
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/cqir_in_if.sv]
// Request channel: command, value and position with valid/ready.
// Depends on cqir_pkg.
`default_nettype none

interface cqir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [cqir_pkg::VALUE_W-1:0] value;
  logic        [cqir_pkg::POS_W-1:0]   position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

`default_nettype wire

[rtl/core/cqir_out_if.sv]
// Response channel: status, removed word and occupancy with valid/ready.
// Depends on cqir_pkg.
`default_nettype none

interface cqir_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [cqir_pkg::VALUE_W-1:0] removed_value;
  logic        [cqir_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, ok, removed_value, occupancy, input ready);
  modport sink   (input valid, ok, removed_value, occupancy, output ready);
endinterface

`default_nettype wire

[rtl/core/cqir_cell.sv]
// One queue slot: holds a word, loads an appended word or takes its neighbor's.
// Depends on cqir_pkg.
`default_nettype none

module cqir_cell #(
  parameter int DATA_WIDTH = cqir_pkg::DATA_WIDTH_DEF
) (
  input  wire                         clk,
  input  cqir_pkg::cell_ctrl_t        ctrl,
  input  wire [DATA_WIDTH-1:0]        load_data,
  input  wire [DATA_WIDTH-1:0]        next_data,
  output logic [DATA_WIDTH-1:0]       data
);
  import cqir_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= next_data;
    end else if (ctrl.load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/collapsing_queue_indexed_remove_top.sv]
// Collapsing queue top: count, per-cell control, result register, cell row.
// Depends on cqir_pkg, cqir_in_if, cqir_out_if, cqir_cell.
// Response valid rises in the cycle after the request transfer.
// Throughput: one item per cycle when rsp drains; remove shifts cells pos..count-2.
// A request is taken whenever the response register is empty or being drained.
// Reset (rst, synchronous): count and response valid clear; slot contents are
// left as they are and are only read after being written.
`default_nettype none

module collapsing_queue_indexed_remove_top #(
  parameter int DEPTH      = cqir_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cqir_pkg::DATA_WIDTH_DEF
) (
  input wire         clk,
  input wire         rst,
  cqir_in_if.sink    req,
  cqir_out_if.source rsp
);
  import cqir_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  out_valid;
  logic                  out_ok;
  logic signed [VALUE_W-1:0] out_removed;
  logic [OCC_W-1:0]      out_occ;

  logic                  take;
  logic                  append_ok;
  logic                  remove_ok;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic [DATA_WIDTH-1:0] store_word;
  logic signed [DATA_WIDTH-1:0] read_word;
  logic signed [VALUE_W-1:0]    removed_next;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  cell_ctrl_t            cell_ctrl [DEPTH];

  assign req.ready = !out_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  assign pos_w = CMP_W'(req.position);
  assign cnt_w = CMP_W'(count);

  assign append_ok = (req.cmd == CMD_APPEND) && (cnt_w < CMP_W'(DEPTH));
  assign remove_ok = (req.cmd == CMD_REMOVE) && (pos_w < cnt_w)
                     && (pos_w < CMP_W'(DEPTH));

  // input is sign-extended to 64 bits, then the low DATA_WIDTH bits are kept
  assign store_word = DATA_WIDTH'(64'(req.value));
  assign read_word  = cell_data[IDX_W'(req.position)];
  assign removed_next = remove_ok ? VALUE_W'(read_word) : '0;

  always_comb begin
    count_next = count;
    if (take && append_ok) begin
      count_next = count + CNT_W'(1);
    end else if (take && remove_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].load  = take && append_ok && (cnt_w == CMP_W'(i));
      // only entries that are present move toward the head
      cell_ctrl[i].shift = take && remove_ok && (CMP_W'(i) >= pos_w)
                           && (CMP_W'(i + 1) < cnt_w);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] nbr;
      if (g + 1 < DEPTH) begin : g_mid
        assign nbr = cell_data[g + 1];
      end else begin : g_last
        assign nbr = cell_data[g];
      end
      cqir_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[g]),
        .load_data(store_word),
        .next_data(nbr),
        .data     (cell_data[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ok      <= append_ok || remove_ok;
      out_removed <= removed_next;
      out_occ     <= OCC_W'(count_next);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.ok            = out_ok;
  assign rsp.removed_value = out_removed;
  assign rsp.occupancy     = out_occ;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("count above depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (take && append_ok) |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not grow count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (take && remove_ok) |=> (count == $past(count) - CNT_W'(1)))
    else $error("remove did not shrink count");

  a_take_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("transfer without response");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_removed == '0))
    else $error("failed item returned data");
`endif

endmodule

`default_nettype wire
